// File: hw/rtl/asoa_pkg.sv
// Shared types and constants of the ADC scan oversampling averager.
`timescale 1ns / 1ps
package asoa_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int MAX_LOG2     = 15;

   localparam int CH_BITS      = $clog2(MAX_CHANNELS);
   localparam int COUNT_BITS   = 4;
   localparam int MUX_BITS     = 6;
   localparam int LOG2_BITS    = 4;
   localparam int SUM_BITS     = 26;
   localparam int TAKEN_BITS   = 16;
   localparam int SEQ_BITS     = 8;
   localparam int MUX_TBL_BITS = MUX_BITS * MAX_CHANNELS;
   localparam int OS_TBL_BITS  = LOG2_BITS * MAX_CHANNELS;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = MUX_TBL_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCAN_LEN         = 2'd0,
      CSR_MUX_TABLE        = 2'd1,
      CSR_OVERSAMPLE_TABLE = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_SELECT = 3'b001,
      PH_SETTLE = 3'b010,
      PH_ACCUM  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]   eff_count;
      logic [MUX_TBL_BITS-1:0] mux_table;
      logic [OS_TBL_BITS-1:0]  oversample_table;
   } cfg_type;

   typedef struct packed {
      logic [MUX_BITS-1:0]    mux_select;
      logic                   average_valid;
      logic [CH_BITS-1:0]     channel;
      logic [SAMPLE_BITS-1:0] average;
      logic [SEQ_BITS-1:0]    sequence_res;
      logic                   scan_last;
   } rsp_type;

endpackage

// File: hw/rtl/asoa_csr.sv
// Configuration registers of the averager and the clamped channel count.
`timescale 1ns / 1ps
module asoa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [asoa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [asoa_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output asoa_pkg::cfg_type                  cfg
);
   import asoa_pkg::*;

   logic [COUNT_BITS-1:0]   count_ff;
   logic [MUX_TBL_BITS-1:0] mux_tbl_ff;
   logic [OS_TBL_BITS-1:0]  os_tbl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_BITS'(1);
         mux_tbl_ff <= '0;
         os_tbl_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SCAN_LEN:         count_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_MUX_TABLE:        mux_tbl_ff <= csr_wdata[MUX_TBL_BITS-1:0];
            CSR_OVERSAMPLE_TABLE: os_tbl_ff  <= csr_wdata[OS_TBL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mux_table        = mux_tbl_ff;
      cfg.oversample_table = os_tbl_ff;
      // zero runs one channel, anything past the channel limit runs all of them
      if (count_ff == '0) begin
         cfg.eff_count = COUNT_BITS'(1);
      end else if (count_ff > COUNT_BITS'(MAX_CHANNELS)) begin
         cfg.eff_count = COUNT_BITS'(MAX_CHANNELS);
      end else begin
         cfg.eff_count = count_ff;
      end
   end

endmodule

// File: hw/rtl/asoa_core.sv
// Scan sequencer, accumulator and rounded average of the averager.
`timescale 1ns / 1ps
module asoa_core (
   input  logic                             clock,
   input  logic                             reset,
   input  asoa_pkg::cfg_type                cfg,
   input  logic                             advance,
   input  logic [asoa_pkg::SAMPLE_BITS-1:0] sample,
   output asoa_pkg::rsp_type                result
);
   import asoa_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [CH_BITS-1:0]      chan_ff, chan_in;
   logic [MUX_BITS-1:0]     mux_ff, mux_in;
   logic [LOG2_BITS-1:0]    log2_ff, log2_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [TAKEN_BITS-1:0]   taken_ff, taken_in;
   logic [SEQ_BITS-1:0]     seq_ff [MAX_CHANNELS];
   logic                    seq_we;

   logic [SUM_BITS-1:0]     sum_acc;
   logic [TAKEN_BITS-1:0]   taken_acc;
   logic [TAKEN_BITS-1:0]   target;
   logic [SUM_BITS:0]       rounded;
   logic [SUM_BITS:0]       shifted;
   logic [COUNT_BITS-1:0]   next_chan;
   logic [SEQ_BITS-1:0]     seq_next;
   logic [LOG2_BITS-1:0]    tbl_log2;

   always_comb begin
      sum_acc   = sum_ff + SUM_BITS'(sample);
      taken_acc = taken_ff + TAKEN_BITS'(1);
      target    = TAKEN_BITS'(1) << log2_ff;
      rounded   = {1'b0, sum_acc} + (SUM_BITS+1)'(target >> 1);
      shifted   = rounded >> log2_ff;
      next_chan = COUNT_BITS'(chan_ff) + COUNT_BITS'(1);
      seq_next  = seq_ff[chan_ff] + SEQ_BITS'(1);
      tbl_log2  = cfg.oversample_table[chan_ff*LOG2_BITS +: LOG2_BITS];
   end

   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      mux_in   = mux_ff;
      log2_in  = log2_ff;
      sum_in   = sum_ff;
      taken_in = taken_ff;
      seq_we   = 1'b0;
      result   = '0;
      case (phase_ff)
         PH_SETTLE: begin
            phase_in = PH_ACCUM;
         end
         PH_ACCUM: begin
            sum_in   = sum_acc;
            taken_in = taken_acc;
            if (taken_acc >= target) begin
               seq_we                = 1'b1;
               result.average_valid  = 1'b1;
               result.channel        = chan_ff;
               result.average        = shifted[SAMPLE_BITS-1:0];
               result.sequence_res   = seq_next;
               phase_in              = PH_SELECT;
               // wrap at the end of the scan, also when the count shrank mid-scan
               if (next_chan >= cfg.eff_count) begin
                  result.scan_last = 1'b1;
                  chan_in          = '0;
               end else begin
                  chan_in = next_chan[CH_BITS-1:0];
               end
            end
         end
         default: begin
            // latch mux code and oversample ratio for the whole channel
            mux_in   = cfg.mux_table[chan_ff*MUX_BITS +: MUX_BITS];
            log2_in  = (tbl_log2 > LOG2_BITS'(MAX_LOG2)) ? LOG2_BITS'(MAX_LOG2) : tbl_log2;
            sum_in   = '0;
            taken_in = '0;
            phase_in = PH_SETTLE;
         end
      endcase
      result.mux_select = mux_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SELECT;
         chan_ff  <= '0;
         mux_ff   <= '0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            seq_ff[i] <= '0;
         end
      end else if (advance) begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         mux_ff   <= mux_in;
         if (seq_we) begin
            seq_ff[chan_ff] <= seq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         log2_ff  <= log2_in;
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
      end
   end

endmodule

// File: hw/rtl/adc_scan_oversample_averager.sv
// Top level of the multichannel ADC scan averager with oversampling.
//
// Usage:
//   req_* carries one finished 10-bit conversion per beat. Every accepted
//   sample yields exactly one rsp_* beat: the mux code now driven and, when
//   that sample closed a channel, the rounded average, channel number,
//   per-channel sequence count and end-of-scan flag (otherwise those are 0).
//   Each channel costs one select sample, one settle sample and 2^k
//   accumulated samples, k from the oversample table.
//   A sample accepted into the sample register moves into the result
//   register, which offers it on rsp_*. Throughput: one sample per cycle
//   while rsp_ready holds; both registers advance whenever the result
//   register is free. When the receiver stalls, the result holds and one
//   more sample is taken into the sample register; req_ready then drops
//   until rsp_ready returns. Reset starts at channel 0 in the select
//   phase, clears the sequence counts and loads a scan length of one and
//   zero tables. Write csr_* only while no beat is in flight.
`timescale 1ns / 1ps
module adc_scan_oversample_averager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [asoa_pkg::SAMPLE_BITS-1:0]   req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [asoa_pkg::MUX_BITS-1:0]      rsp_mux_select,
   output logic                               rsp_average_valid,
   output logic [asoa_pkg::CH_BITS-1:0]       rsp_channel,
   output logic [asoa_pkg::SAMPLE_BITS-1:0]   rsp_average,
   output logic [asoa_pkg::SEQ_BITS-1:0]      rsp_sequence_res,
   output logic                               rsp_scan_last,
   input  logic                               csr_write_en,
   input  logic [asoa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [asoa_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import asoa_pkg::*;

   cfg_type                cfg;
   rsp_type                result;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   advance;

   // move the held sample into the result register when that register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   asoa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   asoa_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .sample  (sample_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_adc_sample;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mux_select    = rsp_ff.mux_select;
   assign rsp_average_valid = rsp_ff.average_valid;
   assign rsp_channel       = rsp_ff.channel;
   assign rsp_average       = rsp_ff.average;
   assign rsp_sequence_res  = rsp_ff.sequence_res;
   assign rsp_scan_last     = rsp_ff.scan_last;

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && in_valid_ff))
      else $error("input held off without a stalled result");

   a_last_has_avg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scan_last) |-> rsp_average_valid)
      else $error("end of scan flagged without an average");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_valid) |->
         (rsp_channel == '0 && rsp_average == '0 && rsp_sequence_res == '0))
      else $error("average fields set on a beat without an average");

   a_wrap_channel: assert property (@(posedge clock) disable iff (reset)
      (advance && result.average_valid && result.scan_last) |=> (u_core.chan_ff == '0))
      else $error("scan did not wrap to channel zero");

endmodule
